// ----- src/tswi_pkg.sv -----
// Shared types and constants for the texture span wrap iterator.
// No dependencies.
`default_nettype none
package tswi_pkg;
	localparam int unsigned MAX_SPANS_DEF = 16;
	localparam logic [30:0] NORM_RESET = 31'd65536;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BEGIN = 2'd1,
		CMD_NEXT  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_COUNT = 2'd0,
		REG_WRAP  = 2'd1,
		REG_NORM  = 2'd2,
		REG_NONE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [3:0]         load_index;
		logic [30:0]        span_size;
		logic [30:0]        span_waste;
		logic signed [31:0] range_start;
		logic signed [31:0] range_end;
	} in_item_t;

	typedef struct packed {
		logic [3:0]         current_span;
		logic signed [31:0] span_pos;
		logic signed [31:0] span_next_pos;
		logic               intersects;
		logic signed [31:0] clip_start;
		logic signed [31:0] clip_end;
		logic               reversed;
		logic               done_res;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_IDLE   = 3'd0,
		OP_LOAD   = 3'd1,
		OP_SETUP  = 3'd2,
		OP_DIVSTP = 3'd3,
		OP_ORIGIN = 3'd4,
		OP_REFR   = 3'd5,
		OP_ADV    = 3'd6,
		OP_EMIT   = 3'd7
	} op_t;

	typedef struct packed {
		op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic skip_stop;
	} dp_stat_t;
endpackage
`default_nettype wire

// ----- src/tswi_datapath.sv -----
// Datapath of the texture span wrap iterator: span tables, divider,
// position registers and result formatting. Uses tswi_pkg.
`default_nettype none
module tswi_datapath #(
	parameter int unsigned MAX_SPANS = tswi_pkg::MAX_SPANS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tswi_pkg::dp_cmd_t   ctl,
	output tswi_pkg::dp_stat_t       stat,
	input  wire tswi_pkg::in_item_t  item,
	input  wire logic [4:0]          span_count,
	input  wire logic                mirror_mode,
	input  wire logic [30:0]         period,
	output tswi_pkg::out_item_t      result
);
	import tswi_pkg::*;
	localparam int IW = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
	localparam int CW = $clog2(MAX_SPANS + 1);

	logic [30:0] size_mem [MAX_SPANS];
	logic [30:0] waste_mem [MAX_SPANS];
	logic [IW-1:0] idx_q;
	logic back_q, flip_q;
	logic [31:0] pos_q, npos_q, lo_q, hi_q;
	logic [31:0] mag_q, rem_q, quo_q;
	logic [5:0] dcnt_q;
	logic neg_q;
	logic [30:0] d_q;
	logic [CW-1:0] n_eff, skip_q;
	logic [IW-1:0] last_idx, nidx;
	logic nback, nflip;
	logic [32:0] trial;
	logic [31:0] quo_adj, org;
	logic [63:0] prod;
	logic [31:0] omag;
	logic [31:0] sa, sb;
	logic p_lt_lo, q_gt_hi, hit, done_w;

	always_comb begin
		if (span_count == 5'd0) n_eff = CW'(1);
		else if (32'(span_count) > MAX_SPANS) n_eff = CW'(MAX_SPANS);
		else n_eff = CW'(span_count);
		last_idx = IW'(n_eff - CW'(1));
	end

	always_comb begin
		logic [IW-1:0] i;
		i = (CW'(idx_q) >= n_eff) ? last_idx : idx_q;
		nidx = i;
		nback = back_q;
		nflip = flip_q;
		if (!mirror_mode) begin
			nidx = (CW'(i) + CW'(1) >= n_eff) ? '0 : i + IW'(1);
		end else if (!back_q) begin
			if (CW'(i) + CW'(1) >= n_eff) begin
				nback = 1'b1;
				nflip = !flip_q;
			end else nidx = i + IW'(1);
		end else begin
			if (i == '0) begin
				nback = 1'b0;
				nflip = !flip_q;
			end else nidx = i - IW'(1);
		end
	end

	assign trial = {rem_q, mag_q[31]} - {2'b0, d_q};
	assign quo_adj = neg_q ? ((rem_q != 0) ? ~quo_q : ~quo_q + 32'd1) : quo_q;
	assign prod = 64'(quo_adj) * 64'(d_q);
	assign org = prod[31:0];
	assign omag = org[31] ? (32'd0 - org) : org;
	assign sa = item.range_start;
	assign sb = item.range_end;
	assign stat.div_done = (dcnt_q == 6'd1);
	assign stat.skip_stop = ($signed(npos_q) > $signed(lo_q)) || (skip_q == CW'(MAX_SPANS));

	always_ff @(posedge clk) begin
		if (ctl.op == OP_LOAD && 32'(item.load_index) < MAX_SPANS) begin
			size_mem[IW'(item.load_index)] <= item.span_size;
			waste_mem[IW'(item.load_index)] <= item.span_waste;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			back_q <= 1'b0;
			flip_q <= 1'b0;
			pos_q <= '0;
			npos_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			dcnt_q <= '0;
			skip_q <= '0;
			mag_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			neg_q <= 1'b0;
			d_q <= '0;
		end else begin
			unique case (ctl.op)
				OP_SETUP: begin
					logic [31:0] s;
					s = ($signed(sa) > $signed(sb)) ? sb : sa;
					flip_q <= $signed(sa) > $signed(sb);
					lo_q <= s;
					hi_q <= ($signed(sa) > $signed(sb)) ? sa : sb;
					neg_q <= s[31];
					mag_q <= s[31] ? (32'd0 - s) : s;
					rem_q <= '0;
					quo_q <= '0;
					d_q <= (period == 31'd0) ? 31'd1 : period;
					dcnt_q <= 6'd32;
					skip_q <= '0;
				end
				OP_DIVSTP: begin
					if (!trial[32]) begin
						rem_q <= trial[31:0];
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= {rem_q[30:0], mag_q[31]};
						quo_q <= {quo_q[30:0], 1'b0};
					end
					mag_q <= {mag_q[30:0], 1'b0};
					dcnt_q <= dcnt_q - 6'd1;
				end
				OP_ORIGIN: begin
					pos_q <= org;
					if (mirror_mode && omag[16]) begin
						idx_q <= last_idx;
						back_q <= 1'b1;
						flip_q <= !flip_q;
					end else begin
						idx_q <= '0;
						back_q <= 1'b0;
					end
				end
				OP_REFR: begin
					npos_q <= pos_q + {1'b0, size_mem[idx_q]} - {1'b0, waste_mem[idx_q]};
				end
				OP_ADV: begin
					pos_q <= npos_q;
					idx_q <= nidx;
					back_q <= nback;
					flip_q <= nflip;
					skip_q <= skip_q + CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	assign p_lt_lo = $signed(pos_q) < $signed(lo_q);
	assign q_gt_hi = $signed(npos_q) > $signed(hi_q);
	assign done_w = $signed(pos_q) >= $signed(hi_q);
	assign hit = !(($signed(npos_q) <= $signed(lo_q)) || done_w);

	always_comb begin
		result.current_span = 4'(idx_q);
		result.span_pos = pos_q;
		result.span_next_pos = npos_q;
		result.intersects = hit;
		result.clip_start = hit ? (p_lt_lo ? lo_q : pos_q) : '0;
		result.clip_end = hit ? (q_gt_hi ? hi_q : npos_q) : '0;
		result.reversed = flip_q;
		result.done_res = done_w;
	end
endmodule
`default_nettype wire

// ----- src/tswi_ctrl.sv -----
// Controller state machine of the texture span wrap iterator.
// Sequences the datapath through tswi_pkg command codes.
`default_nettype none
module tswi_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         in_cmd,
	input  wire tswi_pkg::dp_stat_t stat,
	output tswi_pkg::dp_cmd_t       ctl,
	output logic                    res_load,
	input  wire logic               out_busy
);
	import tswi_pkg::*;
	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_ORG, S_REFR, S_CHK, S_ADVR, S_EMIT, S_NXT
	} state_t;
	state_t state_q;
	logic acc;

	assign in_stall = (state_q != S_IDLE);
	assign acc = in_valid && !in_stall;

	always_comb begin
		ctl.op = OP_IDLE;
		res_load = 1'b0;
		unique case (state_q)
			S_IDLE: if (acc) begin
				if (in_cmd == CMD_LOAD) ctl.op = OP_LOAD;
				else if (in_cmd == CMD_BEGIN) ctl.op = OP_SETUP;
				else if (in_cmd == CMD_NEXT) ctl.op = OP_ADV;
			end
			S_DIV: ctl.op = OP_DIVSTP;
			S_ORG: ctl.op = OP_ORIGIN;
			S_REFR, S_ADVR: ctl.op = OP_REFR;
			S_CHK: if (!stat.skip_stop) ctl.op = OP_ADV;
			S_EMIT: res_load = !out_busy;
			S_NXT: ctl.op = OP_REFR;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (acc) begin
					if (in_cmd == CMD_BEGIN) state_q <= S_DIV;
					else if (in_cmd == CMD_NEXT) state_q <= S_NXT;
				end
				S_DIV: if (stat.div_done) state_q <= S_ORG;
				S_ORG: state_q <= S_REFR;
				S_REFR: state_q <= S_CHK;
				S_CHK: state_q <= stat.skip_stop ? S_EMIT : S_ADVR;
				S_ADVR: state_q <= S_CHK;
				S_NXT: state_q <= S_EMIT;
				S_EMIT: if (!out_busy) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- src/texture_span_wrap_iterator_core.sv -----
// Texture span wrap iterator top level: config registers, controller,
// datapath and output register. Uses tswi_pkg, tswi_ctrl, tswi_datapath.
// Load: span tables written on accept. Next: advance, refresh end, then output.
// Begin: divide to find the origin, then advance and refresh per skipped span.
// One item is in work at a time; a held result does not block a load.
// Reset is asynchronous, active low; the span tables are not cleared.
`default_nettype none
module texture_span_wrap_iterator_core #(
	parameter int unsigned MAX_SPANS = tswi_pkg::MAX_SPANS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire tswi_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output tswi_pkg::out_item_t      out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [30:0]         cfg_data
);
	import tswi_pkg::*;
	logic [4:0] count_q;
	logic wrap_q;
	logic [30:0] norm_q;
	dp_cmd_t ctl;
	dp_stat_t stat;
	out_item_t res;
	logic res_load, busy;

	assign cfg_ready = 1'b1;
	assign busy = out_valid && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 5'd1;
			wrap_q <= 1'b0;
			norm_q <= NORM_RESET;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_COUNT: count_q <= cfg_data[4:0];
				REG_WRAP:  wrap_q <= cfg_data[0];
				REG_NORM:  norm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	tswi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_cmd(in_data.cmd), .stat(stat), .ctl(ctl), .res_load(res_load),
		.out_busy(busy)
	);

	tswi_datapath #(.MAX_SPANS(MAX_SPANS)) u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .stat(stat), .item(in_data),
		.span_count(count_q), .mirror_mode(wrap_q), .period(norm_q),
		.result(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (res_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) out_data <= res;
	end
endmodule
`default_nettype wire

// ----- src/tswi_checker.sv -----
// Port checker for texture_span_wrap_iterator_core, bound to the top level.
// Uses tswi_pkg.
`default_nettype none
module tswi_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_valid,
	input wire logic                in_stall,
	input wire tswi_pkg::in_item_t  in_data,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire tswi_pkg::out_item_t out_data
);
	import tswi_pkg::*;
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("held beat changed");
	a_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.intersects |-> out_data.clip_start == 0 && out_data.clip_end == 0)
		else $error("clip without overlap");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.intersects) else $error("done overlaps");
	a_begin: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.cmd == CMD_BEGIN |=> in_stall) else $error("begin not busy");
endmodule
bind texture_span_wrap_iterator_core tswi_checker u_chk (.*);
`default_nettype wire

// ----- test/tb_texture_span_wrap_iterator_core.sv -----
// Testbench for texture_span_wrap_iterator_core: directed table, then random
// span tables and cover ranges checked against an in-bench span predictor.
// Depends on tswi_pkg and the core; stands alone otherwise.
`default_nettype none
module tb_texture_span_wrap_iterator_core;
	import tswi_pkg::*;

	typedef struct {
		in_item_t  item;
		bit        typed;
		out_item_t res;
	} dir_row_t;

	logic       clk = 0;
	logic       arst_n = 0;
	logic       in_valid = 0;
	logic       in_stall;
	in_item_t   in_data = '0;
	logic       out_valid;
	logic       out_stall = 0;
	out_item_t  out_data;
	logic       cfg_valid = 0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [30:0] cfg_data = '0;

	texture_span_wrap_iterator_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	// Predictor state.
	logic [30:0] span_sz [16];
	logic [30:0] span_ws [16];
	int unsigned cur_span;
	bit          going_back;
	bit          flip;
	logic [31:0] pos = '0, npos = '0, cov_lo = '0, cov_hi = '0;
	logic [4:0]  cnt_reg = 5'd1;
	bit          wrap_reg = 0;
	logic [30:0] norm_reg = NORM_RESET;

	out_item_t expected_spans [$];
	int errors = 0;
	int snd_pct = 0;
	int rcv_pct = 0;
	int quiet = 0;

	function automatic int unsigned spans_in_use();
		int unsigned n;
		n = cnt_reg;
		if (n == 0) n = 1;
		if (n > 16) n = 16;
		return n;
	endfunction

	function automatic void refresh_end();
		int unsigned i;
		i = (cur_span > 15) ? 15 : cur_span;
		npos = pos + {1'b0, span_sz[i]} - {1'b0, span_ws[i]};
	endfunction

	function automatic void step_span();
		int unsigned n, i;
		n = spans_in_use();
		i = cur_span;
		pos = npos;
		if (i >= n) i = n - 1;
		if (!wrap_reg) begin
			i = (i + 1 >= n) ? 0 : i + 1;
		end else if (!going_back) begin
			if (i + 1 >= n) begin
				going_back = 1;
				flip = !flip;
			end else i++;
		end else begin
			if (i == 0) begin
				going_back = 0;
				flip = !flip;
			end else i--;
		end
		cur_span = i;
		refresh_end();
	endfunction

	function automatic void start_cover(logic [31:0] a, logic [31:0] b);
		longint s, e, d, quo, org, t;
		logic [31:0] mag;
		s = longint'($signed(a));
		e = longint'($signed(b));
		d = (norm_reg == 0) ? 1 : longint'(norm_reg);
		if (s > e) begin
			t = s;
			s = e;
			e = t;
			flip = 1;
		end else flip = 0;
		cov_lo = s[31:0];
		cov_hi = e[31:0];
		quo = s / d;
		if ((s % d) != 0 && s < 0) quo--;
		org = quo * d;
		pos = org[31:0];
		mag = pos[31] ? -pos : pos;
		if (wrap_reg && mag[16]) begin
			cur_span = spans_in_use() - 1;
			going_back = 1;
			flip = !flip;
		end else begin
			cur_span = 0;
			going_back = 0;
		end
		refresh_end();
		for (int k = 0; k < 16; k++) begin
			if ($signed(npos) > $signed(cov_lo)) break;
			step_span();
		end
	endfunction

	function automatic out_item_t span_report();
		out_item_t r;
		bit hit;
		hit = !($signed(npos) <= $signed(cov_lo) || $signed(pos) >= $signed(cov_hi));
		r.current_span = cur_span[3:0];
		r.span_pos = pos;
		r.span_next_pos = npos;
		r.intersects = hit;
		r.clip_start = hit ? (($signed(pos) < $signed(cov_lo)) ? cov_lo : pos) : '0;
		r.clip_end = hit ? (($signed(npos) > $signed(cov_hi)) ? cov_hi : npos) : '0;
		r.reversed = flip;
		r.done_res = $signed(pos) >= $signed(cov_hi);
		return r;
	endfunction

	function automatic void predict(in_item_t it, bit typed, out_item_t res);
		out_item_t r;
		case (it.cmd)
			CMD_LOAD: begin
				span_sz[it.load_index] = it.span_size;
				span_ws[it.load_index] = it.span_waste;
			end
			CMD_BEGIN, CMD_NEXT: begin
				if (it.cmd == CMD_BEGIN) start_cover(it.range_start, it.range_end);
				else step_span();
				r = span_report();
				expected_spans.push_back(typed ? res : r);
			end
			default: ;
		endcase
	endfunction

	task automatic send(in_item_t it, bit typed = 0, out_item_t res = '0);
		int g;
		in_data <= it;
		in_valid <= 1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict(it, typed, res);
		g = 0;
		while ($urandom_range(0, 99) < snd_pct && g < 40) g++;
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (expected_spans.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t r, logic [30:0] v);
		drain();
		cfg_index <= r;
		cfg_data <= v;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		case (r)
			REG_COUNT: cnt_reg = v[4:0];
			REG_WRAP: wrap_reg = v[0];
			REG_NORM: norm_reg = v;
			default: ;
		endcase
	endtask

	function automatic in_item_t mk(cmd_t c, int li, logic [30:0] sz, logic [30:0] ws,
			logic [31:0] a, logic [31:0] b);
		in_item_t it;
		it.cmd = c;
		it.load_index = li[3:0];
		it.span_size = sz;
		it.span_waste = ws;
		it.range_start = a;
		it.range_end = b;
		return it;
	endfunction

	function automatic in_item_t noise_item();
		in_item_t it;
		it = {$urandom, $urandom, $urandom, $urandom};
		it.cmd = $urandom_range(0, 3);
		return it;
	endfunction

	task automatic check_field(string name, logic [31:0] e, logic [31:0] g);
		if (e !== g) begin
			$display("%0t mismatch %s expected %h actual %h", $time, name, e, g);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		out_item_t e;
		if (out_valid && !out_stall) begin
			if (expected_spans.size() == 0) begin
				$display("%0t unexpected beat actual %h", $time, out_data);
				errors++;
			end else begin
				e = expected_spans.pop_front();
				check_field("current_span", e.current_span, out_data.current_span);
				check_field("span_pos", e.span_pos, out_data.span_pos);
				check_field("span_next_pos", e.span_next_pos, out_data.span_next_pos);
				check_field("intersects", e.intersects, out_data.intersects);
				check_field("clip_start", e.clip_start, out_data.clip_start);
				check_field("clip_end", e.clip_end, out_data.clip_end);
				check_field("reversed", e.reversed, out_data.reversed);
				check_field("done_res", e.done_res, out_data.done_res);
			end
		end
		out_stall <= ($urandom_range(0, 99) < rcv_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 5000) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		dir_row_t rows [$];
		dir_row_t row;
		out_item_t one;
		logic [30:0] sz;
		int nx;
		int unsigned base;

		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int i = 0; i < 16; i++) begin
			row = '{mk(CMD_LOAD, i, 31'd65536, 31'd0, 0, 0), 0, '0};
			rows.push_back(row);
		end
		one = '{4'd0, 32'd0, 32'd65536, 1'b1, 32'd0, 32'd65536, 1'b0, 1'b0};
		rows.push_back('{mk(CMD_NEXT, 0, 0, 0, 0, 0), 0, '0});
		rows.push_back('{mk(CMD_BEGIN, 0, 0, 0, 32'd0, 32'd65536), 1, one});
		one.reversed = 1'b1;
		rows.push_back('{mk(CMD_BEGIN, 0, 0, 0, 32'd65536, 32'd0), 1, one});
		rows.push_back('{mk(CMD_NONE, 5, '1, '1, '1, '1), 0, '0});
		rows.push_back('{mk(CMD_BEGIN, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff), 0, '0});
		rows.push_back('{mk(CMD_BEGIN, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000), 0, '0});
		rows.push_back('{mk(CMD_LOAD, 0, '1, '1, 0, 0), 0, '0});
		rows.push_back('{mk(CMD_BEGIN, 0, 0, 0, 32'hffff_0000, 32'h0003_0000), 0, '0});
		rows.push_back('{mk(CMD_NEXT, 0, 0, 0, 0, 0), 0, '0});
		foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].res);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin snd_pct = 0; rcv_pct = 0; end
				1: begin snd_pct = 45; rcv_pct = 0; end
				2: begin snd_pct = 0; rcv_pct = 45; end
				default: begin snd_pct = 28; rcv_pct = 28; end
			endcase
			write_reg(REG_COUNT, (ph == 0) ? 31'd0 : (ph == 1) ? 31'd31 :
				(ph == 2) ? 31'd16 : 31'($urandom_range(1, 16)));
			write_reg(REG_WRAP, ph[0]);
			write_reg(REG_NORM, (ph == 0) ? 31'd0 : (ph == 1) ? 31'h7fff_ffff :
				31'($urandom_range(1, 6) * 32768));
			if (ph == 3) write_reg(REG_NONE, 31'($urandom));
			for (int k = 0; k < 16; k++) begin
				sz = 31'($urandom_range(4096, 131072));
				send(mk(CMD_LOAD, k, sz, 31'($urandom_range(0, sz / 2)), 0, 0));
			end
			for (int seq = 0; seq < 18; seq++) begin
				if ($urandom_range(0, 99) < 80) begin
					if ($urandom_range(0, 3) == 0) begin
						sz = 31'($urandom_range(4096, 131072));
						send(mk(CMD_LOAD, $urandom_range(0, 15), sz,
							31'($urandom_range(0, sz / 2)), 0, 0));
					end
					base = $urandom_range(0, 16 * 65536);
					send(mk(CMD_BEGIN, 0, 31'($urandom), 31'($urandom),
						32'(base) - 32'd8 * 65536,
						32'(base) - 32'd8 * 65536 + 32'($urandom_range(0, 6 * 65536))));
					nx = $urandom_range(1, 8);
					repeat (nx) send(mk(CMD_NEXT, $urandom, 31'($urandom), 31'($urandom),
						$urandom, $urandom));
				end else begin
					send(noise_item());
				end
			end
		end
		snd_pct = 10;
		rcv_pct = 10;
		write_reg(REG_WRAP, 31'd1);
		repeat (40) send(noise_item());

		drain();
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_spans.size() == 0) begin
			$display("TB_OK");
		end else begin
			if (expected_spans.size() != 0)
				$display("%0t %0d expected beats never arrived", $time, expected_spans.size());
			$display("TB_ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
